FILE: rtl/clcd_pkg.sv
package clcd_pkg;

  localparam int unsigned TickW = 20;
  localparam int unsigned HoldW = 21;
  localparam int unsigned PhW   = 4;
  localparam int unsigned QDepth = 2;

  // register indexes on the write port
  localparam logic [1:0] CfgPulse   = 2'd0;
  localparam logic [1:0] CfgSettle  = 2'd1;
  localparam logic [1:0] CfgPowerup = 2'd2;

  // phase numbering: init nibble pairs first, then the five byte phases
  localparam logic [PhW-1:0] InitStart = 4'd0;
  localparam logic [PhW-1:0] ByteStart = 4'd6;
  localparam logic [PhW-1:0] LastPh    = 4'd10;

  localparam logic [3:0] InitNibble = 4'h3;
  localparam logic [7:0] CmdHome    = 8'h02;
  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdFuncSet = 8'h20;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_DATA   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_CURSOR = 3'd4,
    OP_FUNC   = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] value;
    logic       row;
    logic [5:0] column;
    logic       data_length;
    logic       two_lines;
    logic       large_font;
  } in_t;

  typedef struct packed {
    logic             register_select;
    logic [3:0]       nibble;
    logic             enable;
    logic [HoldW-1:0] hold_ticks;
    logic             last;
  } out_t;

  // one queued request, already reduced to a byte
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       init;
    logic       dbl_settle;
  } job_t;

  typedef struct packed {
    logic [TickW-1:0] pulse;
    logic [TickW-1:0] settle;
    logic [TickW-1:0] powerup;
  } cfg_t;

endpackage

FILE: rtl/clcd_front.sv
module clcd_front (
  input  clcd_pkg::in_t  in_i,
  input  logic           in_valid_i,
  input  logic           q_full_i,
  output logic           push_o,
  output clcd_pkg::job_t job_o
);
  import clcd_pkg::*;

  logic known;

  always_comb begin
    known          = 1'b1;
    job_o.rs       = 1'b0;
    job_o.data     = in_i.value;
    job_o.init     = 1'b0;
    job_o.dbl_settle = 1'b0;
    unique case (op_e'(in_i.operation))
      OP_INIT: begin
        job_o.data = CmdHome;
        job_o.init = 1'b1;
      end
      OP_CMD: begin
        job_o.data = in_i.value;
      end
      OP_DATA: begin
        job_o.rs = 1'b1;
      end
      OP_CLEAR: begin
        job_o.data       = CmdClear;
        job_o.dbl_settle = 1'b1;
      end
      OP_CURSOR: begin
        // 0x80 | (row ? 0x40 + col : col); col < 0x40 so no carry
        job_o.data = {1'b1, in_i.row, in_i.column};
      end
      OP_FUNC: begin
        job_o.data = CmdFuncSet | {3'b000, in_i.data_length, in_i.two_lines,
                                   in_i.large_font, 2'b00};
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown operations are taken and dropped
  assign push_o = in_valid_i && !q_full_i && known;

endmodule

FILE: rtl/clcd_fifo.sv
module clcd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clcd_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           head_valid_o,
  output clcd_pkg::job_t head_o
);
  import clcd_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign full_o       = (cnt_q == CntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_o |-> !pop_i) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth)) else $error("queue count out of range");

endmodule

FILE: rtl/clcd_back.sv
module clcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clcd_pkg::cfg_t cfg_i,
  input  logic           head_valid_i,
  input  clcd_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output clcd_pkg::out_t out_o
);
  import clcd_pkg::*;

  logic           busy_q, busy_d;
  logic [PhW-1:0] ph_q, ph_d, cur_ph;
  logic [2:0]     k;
  logic           load;
  logic           out_valid_q, out_valid_d;
  out_t           out_q, beat;

  assign cur_ph = busy_q ? ph_q : (head_i.init ? InitStart : ByteStart);
  assign load   = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o  = load && (cur_ph == LastPh);
  assign k      = 3'(cur_ph - ByteStart);

  always_comb begin
    beat.register_select = head_i.rs;
    beat.nibble          = head_i.data[7:4];
    beat.enable          = 1'b0;
    beat.hold_ticks      = '0;
    beat.last            = 1'b0;
    if (cur_ph < ByteStart) begin
      // init: set-up holds the power-up wait, then strobe
      beat.nibble     = InitNibble;
      beat.enable     = cur_ph[0];
      beat.hold_ticks = cur_ph[0] ? HoldW'(cfg_i.pulse) : HoldW'(cfg_i.powerup);
    end else begin
      case (k)
        3'd0: beat.nibble = head_i.data[7:4];
        3'd1: begin
          beat.enable     = 1'b1;
          beat.hold_ticks = HoldW'(cfg_i.pulse);
        end
        3'd2: beat.nibble = head_i.data[3:0];
        3'd3: begin
          beat.nibble     = head_i.data[3:0];
          beat.enable     = 1'b1;
          beat.hold_ticks = HoldW'(cfg_i.pulse);
        end
        default: begin
          beat.nibble     = head_i.data[3:0];
          beat.last       = 1'b1;
          beat.hold_ticks = head_i.dbl_settle ? {cfg_i.settle, 1'b0}
                                              : HoldW'(cfg_i.settle);
        end
      endcase
    end
  end

  always_comb begin
    busy_d      = busy_q;
    ph_d        = ph_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      busy_d      = (cur_ph != LastPh);
      ph_d        = cur_ph + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_busy_ph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (ph_q != InitStart && ph_q <= LastPh))
    else $error("phase index out of run");
  a_busy_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> head_valid_i) else $error("run active without queued job");
  a_last_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> !out_q.enable)
    else $error("final beat with enable high");

endmodule

FILE: rtl/char_lcd_nibble_write_sequencer_core.sv
// 4-bit character-LCD write sequencer. Each request beat is turned into a run
// of bus-phase beats (RS, D7..D4 nibble, E level, hold ticks, last flag),
// high nibble first. A byte is five beats: set-up, strobe, set-up, strobe,
// release held for settle_ticks (twice that for clear). Init is eleven beats:
// three 0x3 nibbles whose set-up holds powerup_ticks, then command 0x02.
// Opcodes 6 and 7 are taken and produce nothing. Rate: one result beat per
// clock while out_stall_i is low and a job is queued; a byte is five beats,
// init eleven, set by the phase sequencer in the back end; a two-entry queue
// sits in front of it, so requests are taken while a run is still going out.
// Config registers may only be written while the block is idle.
module char_lcd_nibble_write_sequencer_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  // config write port
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [19:0]    cfg_wdata_i,
  // request channel
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  clcd_pkg::in_t  in_i,
  // bus-phase channel
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output clcd_pkg::out_t out_o
);
  import clcd_pkg::*;

  cfg_t cfg_q;
  logic q_full, push, pop, head_valid;
  job_t job, head;

  // timing registers; index 3 is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse   <= TickW'(1000);
      cfg_q.settle  <= TickW'(2000);
      cfg_q.powerup <= TickW'(100000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPulse:   cfg_q.pulse   <= cfg_wdata_i;
        CfgSettle:  cfg_q.settle  <= cfg_wdata_i;
        CfgPowerup: cfg_q.powerup <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;

  // decode request into a byte job
  clcd_front u_front (
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  // decouples request intake from phase emission
  clcd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // walks the phases of the head job, one beat per cycle while out_stall_i is low
  clcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

endmodule

FILE: tb/char_lcd_nibble_write_sequencer_core_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_core_tb;
  import clcd_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  // Margin after the last expected beat, so a stray extra beat is still
  // caught before the next phase starts.
  localparam int unsigned DrainCycles   = 32;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned RandPhases    = 6;
  localparam int unsigned ItemsPerPhase = 50;
  localparam int unsigned MaxReports    = 10;

  localparam logic [1:0]       CfgSpare   = 2'd3;   // no register here
  localparam logic [2:0]       OpSpareLo  = 3'd6;
  localparam logic [2:0]       OpSpareHi  = 3'd7;
  localparam logic [7:0]       CmdSetAddr = 8'h80;
  localparam logic [6:0]       LineTwo    = 7'h40;
  localparam logic [TickW-1:0] TickMax    = '1;

  // How a directed row gets its expectation.
  typedef enum logic [1:0] {ByPredictor, ByTypedByte, NoBeats} row_chk_e;

  typedef struct {
    in_t        req;
    row_chk_e   chk;
    logic       rs;
    logic [7:0] bus_byte;
    bit         dbl;
  } dir_row_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_idx   = '0;
  logic [19:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;

  // Local copy of the timing registers, reset values.
  logic [TickW-1:0] pulse_cfg   = 20'd1000;
  logic [TickW-1:0] settle_cfg  = 20'd2000;
  logic [TickW-1:0] powerup_cfg = 20'd100000;

  out_t        bus_phases_due[$];
  int unsigned bad_beats   = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b1;
  int unsigned hold_seq    = 0;

  char_lcd_nibble_write_sequencer_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Bus phase predictor
  // ---------------------------------------------------------------------
  function automatic void push_phase(logic rs, logic [3:0] nib, logic en,
                                     logic [HoldW-1:0] hold, logic last);
    out_t p;
    p.register_select = rs;
    p.nibble          = nib;
    p.enable          = en;
    p.hold_ticks      = hold;
    p.last            = last;
    bus_phases_due.push_back(p);
  endfunction

  // Byte: set-up/strobe for each nibble, high first, then the release beat
  // on the low nibble that carries the settle wait.
  function automatic void push_byte(logic rs, logic [7:0] b, logic [HoldW-1:0] tail_hold);
    push_phase(rs, b[7:4], 1'b0, '0, 1'b0);
    push_phase(rs, b[7:4], 1'b1, HoldW'(pulse_cfg), 1'b0);
    push_phase(rs, b[3:0], 1'b0, '0, 1'b0);
    push_phase(rs, b[3:0], 1'b1, HoldW'(pulse_cfg), 1'b0);
    push_phase(rs, b[3:0], 1'b0, tail_hold, 1'b1);
  endfunction

  function automatic void predict_bus_phases(in_t r);
    logic [6:0]       addr;
    logic [HoldW-1:0] settle_hold;
    settle_hold = HoldW'(settle_cfg);
    case (r.operation)
      OP_INIT: begin
        // power-up wait rides on each init nibble's set-up beat
        for (int i = 0; i < 3; i++) begin
          push_phase(1'b0, InitNibble, 1'b0, HoldW'(powerup_cfg), 1'b0);
          push_phase(1'b0, InitNibble, 1'b1, HoldW'(pulse_cfg), 1'b0);
        end
        push_byte(1'b0, CmdHome, settle_hold);
      end
      OP_CMD:   push_byte(1'b0, r.value, settle_hold);
      OP_DATA:  push_byte(1'b1, r.value, settle_hold);
      OP_CLEAR: push_byte(1'b0, CmdClear, settle_hold + settle_hold);
      OP_CURSOR: begin
        addr = r.row ? LineTwo + {1'b0, r.column} : {1'b0, r.column};
        push_byte(1'b0, CmdSetAddr | {1'b0, addr}, settle_hold);
      end
      OP_FUNC: push_byte(1'b0, CmdFuncSet | {3'b000, r.data_length, r.two_lines,
                                             r.large_font, 2'b00}, settle_hold);
      default: ;  // spare opcodes: taken, nothing comes out
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic in_t mk_req(logic [2:0] op, logic [7:0] v, logic rw,
                                 logic [5:0] col, logic dl, logic nl, logic ft);
    in_t r;
    r.operation   = op;
    r.value       = v;
    r.row         = rw;
    r.column      = col;
    r.data_length = dl;
    r.two_lines   = nl;
    r.large_font  = ft;
    return r;
  endfunction

  function automatic dir_row_t dir(in_t r, row_chk_e c, logic rs, logic [7:0] b, bit dbl);
    dir_row_t d;
    d.req      = r;
    d.chk      = c;
    d.rs       = rs;
    d.bus_byte = b;
    d.dbl      = dbl;
    return d;
  endfunction

  // Mostly legal opcodes with random payload; spare opcodes as noise.
  function automatic in_t random_req();
    in_t r;
    r = in_t'($urandom);
    if ($urandom_range(0, 9) != 0)
      r.operation = 3'($urandom_range(OP_INIT, OP_FUNC));
    else
      r.operation = $urandom_range(0, 1) ? OpSpareLo : OpSpareHi;
    return r;
  endfunction

  task automatic send_req(in_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender goes quiet until every expected beat is back, plus margin.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (bus_phases_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_timing(logic [TickW-1:0] pulse, logic [TickW-1:0] settle,
                                logic [TickW-1:0] powerup, bit stray);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgPulse;
    cfg_wdata <= pulse;
    @(posedge clk);
    cfg_idx   <= CfgSettle;
    cfg_wdata <= settle;
    @(posedge clk);
    cfg_idx   <= CfgPowerup;
    cfg_wdata <= powerup;
    @(posedge clk);
    if (stray) begin
      // out-of-range index must leave all timing alone
      cfg_idx   <= CfgSpare;
      cfg_wdata <= 20'($urandom);
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    pulse_cfg   = pulse;
    settle_cfg  = settle;
    powerup_cfg = powerup;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin : bus_receiver
    int unsigned hold_seen;
    hold_seen = 0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: each beat against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : phase_check
    out_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_phases_due.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MaxReports)
          $display("unexpected bus phase beat: %p", out_data);
      end else begin
        due = bus_phases_due.pop_front();
        if (due.register_select !== out_data.register_select ||
            due.nibble !== out_data.nibble || due.enable !== out_data.enable ||
            due.hold_ticks !== out_data.hold_ticks || due.last !== out_data.last) begin
          bad_beats++;
          if (bad_beats <= MaxReports)
            $display("beat mismatch: exp rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                     due.register_select, due.nibble, due.enable, due.hold_ticks,
                     due.last, "  got rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                     out_data.register_select, out_data.nibble, out_data.enable,
                     out_data.hold_ticks, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    script [22];
    in_t         r;
    int unsigned sent;
    int unsigned n;

    // Directed rows at reset timing. Typed bytes are the obvious ones:
    // fixed commands and the address / flag extremes.
    script = '{
      dir(mk_req(OP_INIT,   8'h00, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0), ByPredictor, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_CMD,    8'h00, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0), ByTypedByte, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_CMD,    8'hFF, 1'b1, 6'h3F, 1'b1, 1'b1, 1'b1), ByTypedByte, 1'b0, 8'hFF, 1'b0),
      dir(mk_req(OP_DATA,   8'h00, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0), ByTypedByte, 1'b1, 8'h00, 1'b0),
      dir(mk_req(OP_DATA,   8'hFF, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0), ByTypedByte, 1'b1, 8'hFF, 1'b0),
      dir(mk_req(OP_DATA,   8'hA5, 1'b1, 6'h2A, 1'b0, 1'b1, 1'b0), ByPredictor, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_CLEAR,  8'hFF, 1'b1, 6'h3F, 1'b1, 1'b1, 1'b1), ByTypedByte, 1'b0, 8'h01, 1'b1),
      dir(mk_req(OP_CURSOR, 8'h00, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0), ByTypedByte, 1'b0, 8'h80, 1'b0),
      dir(mk_req(OP_CURSOR, 8'h00, 1'b0, 6'h3F, 1'b0, 1'b0, 1'b0), ByTypedByte, 1'b0, 8'hBF, 1'b0),
      dir(mk_req(OP_CURSOR, 8'h00, 1'b1, 6'h00, 1'b0, 1'b0, 1'b0), ByTypedByte, 1'b0, 8'hC0, 1'b0),
      dir(mk_req(OP_CURSOR, 8'hFF, 1'b1, 6'h3F, 1'b1, 1'b1, 1'b1), ByTypedByte, 1'b0, 8'hFF, 1'b0),
      dir(mk_req(OP_FUNC,   8'h00, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0), ByTypedByte, 1'b0, 8'h20, 1'b0),
      dir(mk_req(OP_FUNC,   8'hFF, 1'b1, 6'h3F, 1'b1, 1'b1, 1'b1), ByTypedByte, 1'b0, 8'h3C, 1'b0),
      dir(mk_req(OP_FUNC,   8'h00, 1'b0, 6'h00, 1'b1, 1'b0, 1'b0), ByPredictor, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_FUNC,   8'h00, 1'b0, 6'h00, 1'b0, 1'b1, 1'b0), ByPredictor, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_FUNC,   8'h00, 1'b0, 6'h00, 1'b0, 1'b0, 1'b1), ByPredictor, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OpSpareLo, 8'hFF, 1'b1, 6'h3F, 1'b1, 1'b1, 1'b1), NoBeats,     1'b0, 8'h00, 1'b0),
      dir(mk_req(OpSpareHi, 8'h00, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0), NoBeats,     1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_CMD,    8'h5A, 1'b0, 6'h15, 1'b0, 1'b0, 1'b0), ByPredictor, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_DATA,   8'h3C, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0), ByPredictor, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_INIT,   8'hFF, 1'b1, 6'h3F, 1'b1, 1'b1, 1'b1), ByPredictor, 1'b0, 8'h00, 1'b0),
      dir(mk_req(OP_CURSOR, 8'h00, 1'b1, 6'h15, 1'b0, 1'b0, 1'b0), ByPredictor, 1'b0, 8'h00, 1'b0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_req(script[i].req);
      case (script[i].chk)
        ByPredictor: predict_bus_phases(script[i].req);
        ByTypedByte: push_byte(script[i].rs, script[i].bus_byte,
                               script[i].dbl ? HoldW'(settle_cfg) + HoldW'(settle_cfg)
                                             : HoldW'(settle_cfg));
        default: ;
      endcase
    end
    wait_drained();

    // Random phases, each under its own timing. Phase 0 is the minimum
    // timing (and pokes the unused index), phase 1 the maximum, the rest
    // random. Last phase runs with no idling on either side.
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       program_timing(20'd1, '0, '0, 1'b1);
        1:       program_timing(TickMax, TickMax, TickMax, 1'b0);
        default: program_timing(20'($urandom_range(1, TickMax)),
                                20'($urandom_range(0, TickMax)),
                                20'($urandom_range(0, TickMax)), 1'b0);
      endcase
      idle_on = (ph != RandPhases - 1);
      sent = 0;
      n    = 0;
      while (sent < ItemsPerPhase) begin
        // long receiver hold-off while requests keep coming: fills the queue
        if (ph == 1 && n == 10) hold_seq++;
        // sender pause mid-phase until everything is back
        if (ph == 2 && n == 28) wait_drained();
        r = random_req();
        send_req(r);
        predict_bus_phases(r);
        if (r.operation <= OP_FUNC) sent++;
        n++;
      end
      wait_drained();
    end

    if (bad_beats == 0 && bus_phases_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/clcd_pkg.sv
rtl/clcd_front.sv
rtl/clcd_fifo.sv
rtl/clcd_back.sv
rtl/char_lcd_nibble_write_sequencer_core.sv
tb/char_lcd_nibble_write_sequencer_core_tb.sv
